@@ rtl/core/hdep_pkg.sv @@
// shared types, constants and lookup functions for the http date parser
// no dependencies
package hdep_pkg;

  localparam int unsigned BODY_LEN = 29;
  localparam int unsigned EPOCH_W  = 39;

  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_T     = 8'h54;

  // year offset keeps the shifted year non-negative
  localparam logic [13:0] YEAR_OFS  = 14'd400;
  // ceil(2^16 / 25), exact for quotients below 2600
  localparam logic [11:0] RECIP_25  = 12'd2622;
  // 719468 + 146097 + 1
  localparam logic [24:0] DAYS_BIAS = 25'd865566;
  localparam logic signed [17:0] DAY_SEC = 18'sd86400;

  typedef enum logic [2:0] {
    S_RUN,
    S_MUL,
    S_DAYS,
    S_SEC,
    S_SUM,
    S_OUT
  } state_t;

  typedef struct packed {
    logic take;
    logic mul;
    logic days;
    logic sec;
    logic finish;
  } cmd_t;

  // returns {found, index}
  function automatic logic [4:0] month_lookup(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
    logic [4:0] r;
    unique case ({a, b, c})
      "Jan": r = {1'b1, 4'd0};
      "Feb": r = {1'b1, 4'd1};
      "Mar": r = {1'b1, 4'd2};
      "Apr": r = {1'b1, 4'd3};
      "May": r = {1'b1, 4'd4};
      "Jun": r = {1'b1, 4'd5};
      "Jul": r = {1'b1, 4'd6};
      "Aug": r = {1'b1, 4'd7};
      "Sep": r = {1'b1, 4'd8};
      "Oct": r = {1'b1, 4'd9};
      "Nov": r = {1'b1, 4'd10};
      "Dec": r = {1'b1, 4'd11};
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // day of a year that starts in march
  function automatic logic [8:0] month_doy(input logic [3:0] mon);
    logic [8:0] r;
    unique case (mon)
      4'd0:  r = 9'd306;
      4'd1:  r = 9'd337;
      4'd2:  r = 9'd0;
      4'd3:  r = 9'd31;
      4'd4:  r = 9'd61;
      4'd5:  r = 9'd92;
      4'd6:  r = 9'd122;
      4'd7:  r = 9'd153;
      4'd8:  r = 9'd184;
      4'd9:  r = 9'd214;
      4'd10: r = 9'd245;
      4'd11: r = 9'd275;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/hdep_ctrl.sv @@
// controller for the http date parser: byte intake, conversion sequence, result hand-off
// depends on hdep_pkg
module hdep_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           last,
  input  logic           out_ready,
  output logic           in_ready,
  output logic           out_valid,
  output hdep_pkg::cmd_t cmd
);
  import hdep_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RUN;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      S_RUN: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
        if (in_valid && last) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DAYS;
      end
      S_DAYS: begin
        cmd.days   = 1'b1;
        state_next = S_SEC;
      end
      S_SEC: begin
        cmd.sec    = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.finish = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        // a final item waits until the result is taken
        in_ready  = out_ready | ~last;
        cmd.take  = in_valid & in_ready;
        if (out_ready) begin
          state_next = (in_valid && last) ? S_MUL : S_RUN;
        end
      end
      default: state_next = S_RUN;
    endcase
  end

endmodule

@@ rtl/core/hdep_dp.sv @@
// datapath for the http date parser: field capture, checks and epoch arithmetic
// depends on hdep_pkg
module hdep_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  hdep_pkg::cmd_t                     cmd,
  input  logic [7:0]                         ch,
  output logic                               valid_res,
  output logic signed [hdep_pkg::EPOCH_W-1:0] epoch_seconds
);
  import hdep_pkg::*;

  logic [5:0]  position, position_next;
  logic        started, started_next;
  logic        bad, bad_next;
  logic [15:0] month_chars, month_chars_next;
  logic [6:0]  day_value, day_value_next;
  logic [13:0] year_value, year_value_next;
  logic [6:0]  hour_value, hour_value_next;
  logic [6:0]  minute_value, minute_value_next;
  logic [6:0]  second_value, second_value_next;

  logic        blank, digit;
  logic [3:0]  dval;
  logic [4:0]  mlook;

  function automatic logic [6:0] add2(input logic [6:0] acc, input logic [3:0] d);
    return 7'({acc, 3'b000}) + 7'({acc, 1'b0}) + {3'b000, d};
  endfunction

  assign blank = (ch == CH_SP) || (ch == CH_TAB);
  assign digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign dval  = ch[3:0];
  assign mlook = month_lookup(month_chars[7:0], month_chars[15:8], ch);

  always_comb begin
    position_next     = position;
    started_next      = started;
    bad_next          = bad;
    month_chars_next  = month_chars;
    day_value_next    = day_value;
    year_value_next   = year_value;
    hour_value_next   = hour_value;
    minute_value_next = minute_value;
    second_value_next = second_value;
    if (started || !blank) begin
      started_next = 1'b1;
      if (position < 6'(BODY_LEN)) begin
        position_next = position + 6'd1;
        unique case (position)
          6'd3: if (ch != CH_COMMA) bad_next = 1'b1;
          6'd4, 6'd7, 6'd11, 6'd16, 6'd25: if (ch != CH_SP) bad_next = 1'b1;
          6'd19, 6'd22: if (ch != CH_COLON) bad_next = 1'b1;
          6'd5, 6'd6: begin
            if (digit) day_value_next = add2(day_value, dval);
            else bad_next = 1'b1;
          end
          6'd17, 6'd18: begin
            if (digit) hour_value_next = add2(hour_value, dval);
            else bad_next = 1'b1;
          end
          6'd20, 6'd21: begin
            if (digit) minute_value_next = add2(minute_value, dval);
            else bad_next = 1'b1;
          end
          6'd23, 6'd24: begin
            if (digit) second_value_next = add2(second_value, dval);
            else bad_next = 1'b1;
          end
          6'd12, 6'd13, 6'd14, 6'd15: begin
            if (digit) begin
              year_value_next = 14'({year_value, 3'b000}) + 14'({year_value, 1'b0})
                              + {10'd0, dval};
            end else begin
              bad_next = 1'b1;
            end
          end
          6'd8: month_chars_next = {8'h00, ch};
          6'd9: month_chars_next = month_chars | {ch, 8'h00};
          6'd10: begin
            if (!mlook[4]) bad_next = 1'b1;
            month_chars_next = {12'd0, mlook[3:0]};
          end
          6'd26: if (ch != CH_G) bad_next = 1'b1;
          6'd27: if (ch != CH_M) bad_next = 1'b1;
          6'd28: if (ch != CH_T) bad_next = 1'b1;
          default: ;
        endcase
      end else if (!blank) begin
        bad_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      position     <= '0;
      started      <= 1'b0;
      bad          <= 1'b0;
      month_chars  <= '0;
      day_value    <= '0;
      year_value   <= '0;
      hour_value   <= '0;
      minute_value <= '0;
      second_value <= '0;
    end else if (cmd.take) begin
      position     <= position_next;
      started      <= started_next;
      bad          <= bad_next;
      month_chars  <= month_chars_next;
      day_value    <= day_value_next;
      year_value   <= year_value_next;
      hour_value   <= hour_value_next;
      minute_value <= minute_value_next;
      second_value <= second_value_next;
    end
  end

  // conversion, parse registers stay put until the finish step
  logic [3:0]         mon;
  logic [13:0]        yy;
  logic [11:0]        q;
  logic [23:0]        prod;
  logic [6:0]         c100;
  logic [4:0]         c400;
  logic [21:0]        day_pos;
  logic signed [24:0] days;
  logic [18:0]        hms;
  logic signed [42:0] dprod;
  logic signed [39:0] dsec;
  logic signed [39:0] total;
  logic               ok;

  assign mon     = month_chars[3:0];
  assign yy      = year_value + YEAR_OFS - {13'd0, (mon < 4'd2)};
  assign q       = yy[13:2];
  assign c100    = prod[22:16];
  assign c400    = c100[6:2];
  assign day_pos = 22'(yy) * 22'd365 + 22'(q) + 22'(c400) + 22'(month_doy(mon))
                 + 22'(day_value);
  assign dprod   = days * DAY_SEC;
  assign total   = dsec + $signed({21'd0, hms});
  assign ok      = started && !bad && (position == 6'(BODY_LEN)) && (total != '1);

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= 24'(q) * 24'(RECIP_25);
    end
    if (cmd.days) begin
      days <= $signed(25'(day_pos) - 25'(c100) - DAYS_BIAS);
      hms  <= 19'(hour_value) * 19'd3600 + 19'(minute_value) * 19'd60
            + 19'(second_value);
    end
    if (cmd.sec) begin
      dsec <= dprod[39:0];
    end
    if (cmd.finish) begin
      valid_res     <= ok;
      epoch_seconds <= ok ? total[EPOCH_W-1:0] : '0;
    end
  end

endmodule

@@ rtl/core/http_date_to_epoch_parser.sv @@
// http date parser: one byte per cycle while in_ready is high, epoch seconds after the final item
// throughput: one byte per cycle while in_ready is high; after a final byte the conversion states take no input
// the conversion runs as a fixed sequence of steps: mul, days, sec and finish
// synchronous reset clears the parse state and the controller; depends on hdep_pkg
module http_date_to_epoch_parser (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         ch,
  input  logic                               last,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               valid_res,
  output logic signed [hdep_pkg::EPOCH_W-1:0] epoch_seconds
);
  import hdep_pkg::*;

  cmd_t cmd;

  hdep_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last      (last),
    .out_ready (out_ready),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  hdep_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .ch            (ch),
    .valid_res     (valid_res),
    .epoch_seconds (epoch_seconds)
  );

endmodule

@@ tb/epoch_date_checker.sv @@
`timescale 1ns / 1ps
// checker for the http date parser: watches both channels, predicts each date result
// and compares it with the block's output; depends on hdep_pkg
module epoch_date_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [7:0]                          ch,
  input  logic                                last,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic                                valid_res,
  input  logic signed [hdep_pkg::EPOCH_W-1:0] epoch_seconds,
  output int                                  pending,
  output int                                  fail_count
);
  import hdep_pkg::*;

  typedef struct packed {
    logic               ok;
    logic [EPOCH_W-1:0] secs;
  } date_result_t;

  localparam logic [287:0] MONTH_TEXT = "JanFebMarAprMayJunJulAugSepOctNovDec";
  localparam logic [31:0]  GMT_TAIL   = {CH_SP, CH_G, CH_M, CH_T};

  date_result_t due_dates[$];
  int           fails;

  logic [5:0]  body_pos;
  logic        past_blanks;
  logic        malformed;
  logic [15:0] month_acc;
  logic [6:0]  day_acc;
  logic [13:0] year_acc;
  logic [6:0]  hour_acc;
  logic [6:0]  min_acc;
  logic [6:0]  sec_acc;

  assign fail_count = fails;

  function automatic logic is_blank(input logic [7:0] c);
    return c == CH_SP || c == CH_TAB;
  endfunction

  function automatic void clear_parse();
    body_pos    = '0;
    past_blanks = 1'b0;
    malformed   = 1'b0;
    month_acc   = '0;
    day_acc     = '0;
    year_acc    = '0;
    hour_acc    = '0;
    min_acc     = '0;
    sec_acc     = '0;
  endfunction

  function automatic void take_char(input logic [5:0] p, input logic [7:0] c);
    logic       dig;
    logic [3:0] dv;
    int         found;
    dig = (c >= CH_ZERO) && (c <= CH_NINE);
    dv  = c[3:0];
    case (p)
      3: if (c != CH_COMMA) malformed = 1'b1;
      4, 7, 11, 16: if (c != CH_SP) malformed = 1'b1;
      19, 22: if (c != CH_COLON) malformed = 1'b1;
      5, 6: if (!dig) malformed = 1'b1; else day_acc = 7'(day_acc * 10 + dv);
      17, 18: if (!dig) malformed = 1'b1; else hour_acc = 7'(hour_acc * 10 + dv);
      20, 21: if (!dig) malformed = 1'b1; else min_acc = 7'(min_acc * 10 + dv);
      23, 24: if (!dig) malformed = 1'b1; else sec_acc = 7'(sec_acc * 10 + dv);
      12, 13, 14, 15: if (!dig) malformed = 1'b1; else year_acc = 14'(year_acc * 10 + dv);
      8: month_acc = {8'h00, c};
      9: month_acc[15:8] = c;
      10: begin
        found = -1;
        for (int i = 0; i < 12; i++) begin
          if (MONTH_TEXT[(11 - i) * 24 +: 24] == {month_acc[7:0], month_acc[15:8], c}) found = i;
        end
        if (found < 0) malformed = 1'b1;
        month_acc = (found < 0) ? 16'd0 : 16'(found);
      end
      25, 26, 27, 28: if (c != GMT_TAIL[(28 - p) * 8 +: 8]) malformed = 1'b1;
      default: ;
    endcase
  endfunction

  // epoch seconds from civil date, via days with a march-based year
  function automatic longint imf_epoch();
    longint y, m, mp, era, yoe, doy, doe, days;
    y = year_acc;
    m = month_acc % 12;
    if (m < 2) y = y - 1;
    mp   = (m + 10) % 12;
    era  = ((y >= 0) ? y : y - 399) / 400;
    yoe  = y - era * 400;
    doy  = (153 * mp + 2) / 5;
    doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    days = era * 146097 + doe - 719468 + longint'(day_acc) - 1;
    return days * 86400 + longint'(hour_acc) * 3600 + longint'(min_acc) * 60 +
           longint'(sec_acc);
  endfunction

  always @(posedge clk) begin : watch
    date_result_t want;
    logic         ok;
    longint       secs;
    if (rst) begin
      clear_parse();
      due_dates.delete();
      fails = 0;
      pending <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_dates.size() == 0) begin
          $error("result with no date pending: valid_res=%0b epoch_seconds=%0d",
                 valid_res, epoch_seconds);
          fails++;
        end else begin
          want = due_dates.pop_front();
          if (valid_res !== want.ok) begin
            $error("valid_res: expected %0b, got %0b", want.ok, valid_res);
            fails++;
          end
          if (epoch_seconds !== want.secs) begin
            $error("epoch_seconds: expected %0d, got %0d", $signed(want.secs), epoch_seconds);
            fails++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (past_blanks || !is_blank(ch)) begin
          past_blanks = 1'b1;
          if (body_pos < BODY_LEN) begin
            take_char(body_pos, ch);
            body_pos = body_pos + 6'd1;
          end else if (!is_blank(ch)) begin
            malformed = 1'b1;
          end
        end
        if (last) begin
          ok   = past_blanks && !malformed && body_pos == BODY_LEN;
          secs = 0;
          if (ok) begin
            secs = imf_epoch();
            if (secs == -1) ok = 1'b0;
          end
          want.ok   = ok;
          want.secs = ok ? secs[EPOCH_W-1:0] : '0;
          due_dates.push_back(want);
          clear_parse();
        end
      end
      pending <= due_dates.size();
    end
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// top of the http date parser testbench: clock, reset, date header stimulus and verdict
// depends on hdep_pkg, http_date_to_epoch_parser and epoch_date_checker
module tb_top;
  import hdep_pkg::*;

  localparam logic [287:0] MONTH_TEXT = "JanFebMarAprMayJunJulAugSepOctNovDec";

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_ready;
  logic [7:0]                ch;
  logic                      last;
  logic                      out_valid;
  logic                      out_ready;
  logic                      valid_res;
  logic signed [EPOCH_W-1:0] epoch_seconds;
  int                        pending;
  int                        fail_count;

  int         send_gap_pct;
  int         recv_gap_pct;
  int         items_sent;
  int         dates_sent;
  logic [7:0] msg_q[$];

  http_date_to_epoch_parser dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .ch            (ch),
    .last          (last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .valid_res     (valid_res),
    .epoch_seconds (epoch_seconds)
  );

  epoch_date_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .ch            (ch),
    .last          (last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .valid_res     (valid_res),
    .epoch_seconds (epoch_seconds),
    .pending       (pending),
    .fail_count    (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_gap_pct);
  end

  initial begin
    #2ms;
    $display("http_date_to_epoch_parser regression: fail");
    $finish;
  end

  task automatic send_byte(input logic [7:0] c, input logic fin);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    ch       <= c;
    last     <= fin;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_msg();
    for (int i = 0; i < msg_q.size(); i++) send_byte(msg_q[i], i == msg_q.size() - 1);
    msg_q.delete();
    dates_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) msg_q.push_back(s[i]);
    send_msg();
  endtask

  // hold the sender until every pending result is out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic push_blanks(input int n);
    for (int i = 0; i < n; i++) msg_q.push_back($urandom_range(1) ? CH_SP : CH_TAB);
  endtask

  task automatic push_num(input int v, input int digits);
    int div;
    div = 1;
    for (int i = 1; i < digits; i++) div = div * 10;
    for (int i = 0; i < digits; i++) begin
      msg_q.push_back(CH_ZERO + 8'((v / div) % 10));
      div = div / 10;
    end
  endtask

  task automatic push_date(input int day, input logic [23:0] mon, input int year,
                           input int hh, input int mm, input int ss);
    logic [7:0] wd;
    wd = 8'($urandom_range(255));
    if (wd == CH_SP || wd == CH_TAB) wd = CH_T;
    msg_q.push_back(wd);
    msg_q.push_back(8'($urandom_range(255)));
    msg_q.push_back(8'($urandom_range(255)));
    msg_q.push_back(CH_COMMA);
    msg_q.push_back(CH_SP);
    push_num(day, 2);
    msg_q.push_back(CH_SP);
    msg_q.push_back(mon[23:16]);
    msg_q.push_back(mon[15:8]);
    msg_q.push_back(mon[7:0]);
    msg_q.push_back(CH_SP);
    push_num(year, 4);
    msg_q.push_back(CH_SP);
    push_num(hh, 2);
    msg_q.push_back(CH_COLON);
    push_num(mm, 2);
    msg_q.push_back(CH_COLON);
    push_num(ss, 2);
    msg_q.push_back(CH_SP);
    msg_q.push_back(CH_G);
    msg_q.push_back(CH_M);
    msg_q.push_back(CH_T);
  endtask

  task automatic push_random_date();
    logic        tame;
    logic [23:0] mon;
    tame = 1'($urandom_range(1));
    mon  = MONTH_TEXT[(11 - $urandom_range(11)) * 24 +: 24];
    if ($urandom_range(19) == 0) mon = {8'($urandom_range(255)), 16'($urandom_range(65535))};
    push_blanks($urandom_range(3));
    push_date(tame ? $urandom_range(1, 31) : $urandom_range(99), mon,
              tame ? $urandom_range(1900, 2100) : $urandom_range(9999),
              tame ? $urandom_range(23) : $urandom_range(99),
              tame ? $urandom_range(59) : $urandom_range(99),
              tame ? $urandom_range(59) : $urandom_range(99));
  endtask

  task automatic random_msg();
    int kind;
    int n;
    kind = $urandom_range(9);
    if (kind <= 8) push_random_date();
    case (kind)
      6: msg_q[$urandom_range(msg_q.size() - 1)] = 8'($urandom_range(255));
      7: begin
        n = $urandom_range(1, msg_q.size() - 1);
        while (msg_q.size() > n) msg_q.delete(msg_q.size() - 1);
      end
      8: begin
        push_blanks($urandom_range(2));
        msg_q.push_back(8'($urandom_range(33, 255)));
        push_blanks($urandom_range(2));
      end
      9: begin
        n = $urandom_range(1, 40);
        for (int i = 0; i < n; i++) msg_q.push_back(8'($urandom_range(255)));
      end
      default: push_blanks($urandom_range(3));
    endcase
    send_msg();
  endtask

  initial begin
    int phase_items;
    int phase_dates;
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    ch           <= 8'h00;
    last         <= 1'b0;
    send_gap_pct = 14;
    recv_gap_pct = 82;
    items_sent   = 0;
    dates_sent   = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_text(" ");
    send_text("X");
    send_text("Sun, 06 Nov 1994 08:49:37 GMT");
    send_text("Wed, 31 Dec 1969 23:59:59 GMT");
    send_text("\t Thu, 01 Jan 1970 00:00:00 GMT \t");
    send_text("Sat, 00 Jan 0000 00:00:00 GMT");
    send_text("Fri, 99 Dec 9999 99:99:99 GMT");
    send_text("Mon, 01 Feb 2000 00:00:00 GMTx");
    send_text("Tue, 15 jan 2021 12:30:45 GMT");
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_gap_pct = (phase == 0) ? 14 : (phase == 1) ? 82 : 0;
      recv_gap_pct = (phase == 0) ? 82 : (phase == 1) ? 14 : 0;
      phase_items  = items_sent;
      phase_dates  = dates_sent;
      while (items_sent - phase_items < 230 || dates_sent - phase_dates < 8) begin
        random_msg();
        if ($urandom_range(11) == 0) drain();
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("http_date_to_epoch_parser regression: pass");
    end else begin
      $display("http_date_to_epoch_parser regression: fail");
    end
    $finish;
  end

endmodule
